@@ hw/rtl/agk_pkg.sv @@
// ----------------------------------------------------------------------------
// agk_pkg
// Types, constants and helper functions shared by the angle and bias filter.
// ----------------------------------------------------------------------------
package agk_pkg;

    localparam int DT_FRAC_BITS = 24;
    localparam int WIDE_W       = 66;

    localparam int NOISE_QA_MILLI = 1;
    localparam int NOISE_QB_MILLI = 3;
    localparam int NOISE_R_MILLI  = 30;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_MUL_AR,
        ST_UPD_AR,
        ST_MUL_D,
        ST_UPD_D,
        ST_MUL_P0,
        ST_UPD_P0,
        ST_MUL_P3,
        ST_UPD_P3,
        ST_SUM,
        ST_CHECK,
        ST_DIV0_GO,
        ST_DIV0_WAIT,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_MUL_KA,
        ST_UPD_KA,
        ST_MUL_KB,
        ST_UPD_KB,
        ST_MUL_Q0,
        ST_UPD_Q0,
        ST_MUL_Q1,
        ST_UPD_Q1,
        ST_MUL_Q2,
        ST_UPD_Q2,
        ST_MUL_Q3,
        ST_UPD_Q3,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               en;
        logic               cov_shift;
        logic signed [32:0] a;
        logic signed [32:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic [32:0]        den;
    } t_div_req;

    function automatic logic signed [WIDE_W-1:0] wide32(input logic signed [31:0] v);
        return {{(WIDE_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ hw/rtl/agk_mul.sv @@
// ----------------------------------------------------------------------------
// agk_mul
// Shared signed multiplier with a product register and round-to-nearest
// scaling by either the time step or the covariance fraction width.
// ----------------------------------------------------------------------------
module agk_mul import agk_pkg::*; #(
    parameter int COV_FRAC_BITS = 24
) (
    input  logic                     i_clk,
    input  t_mul_req                 i_req,
    output logic signed [WIDE_W-1:0] o_round
);

    localparam logic signed [WIDE_W-1:0] HALF_DT  = WIDE_W'(1) <<< (DT_FRAC_BITS - 1);
    localparam logic signed [WIDE_W-1:0] HALF_COV = WIDE_W'(1) <<< (COV_FRAC_BITS - 1);

    logic signed [WIDE_W-1:0] r_prod;
    logic                     r_cov;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
            r_cov  <= i_req.cov_shift;
        end
    end

    always_comb begin
        if (r_cov) begin
            o_round = (r_prod + HALF_COV) >>> COV_FRAC_BITS;
        end else begin
            o_round = (r_prod + HALF_DT) >>> DT_FRAC_BITS;
        end
    end

endmodule

@@ hw/rtl/agk_div.sv @@
// ----------------------------------------------------------------------------
// agk_div
// Restoring divider for the gains: round(num * 2^C / den), ties away from
// zero, one quotient bit per cycle, saturated to signed 32 bits.
// ----------------------------------------------------------------------------
module agk_div import agk_pkg::*; #(
    parameter int COV_FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_busy,
    output logic signed [31:0] o_quot
);

    localparam int QW    = 33;
    localparam int CNT_W = $clog2(QW + 1);

    logic [63:0]      start_mag;
    logic [63:0]      start_nd;
    logic [QW-1:0]    start_hi;
    logic [QW:0]      step_t;
    logic             step_ge;
    logic [QW:0]      step_diff;
    logic [QW-1:0]    quot_mag;

    logic [QW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;
    logic [QW-1:0]    r_den;
    logic             r_neg;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    always_comb begin
        if (i_req.num[31]) begin
            start_mag = 64'(-{{32{i_req.num[31]}}, i_req.num});
        end else begin
            start_mag = {32'b0, i_req.num};
        end
        start_nd  = (start_mag << COV_FRAC_BITS) + {31'b0, i_req.den >> 1};
        start_hi  = {2'b0, start_nd[63:QW]};
        step_t    = {r_rem, r_quo[QW-1]};
        step_ge   = step_t >= {1'b0, r_den};
        step_diff = step_t - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= start_hi;
            r_quo <= start_nd[QW-1:0];
            r_den <= i_req.den;
            r_neg <= i_req.num[31];
            r_ovf <= start_hi >= i_req.den;
        end else if (r_busy) begin
            r_rem <= step_ge ? step_diff[QW-1:0] : step_t[QW-1:0];
            r_quo <= {r_quo[QW-2:0], step_ge};
        end
    end

    always_comb begin
        if (r_ovf || (r_quo > {2'b0, 31'h0} + (QW'(1) << 31))) begin
            quot_mag = QW'(1) << 31;
        end else begin
            quot_mag = r_quo;
        end
        if (r_neg) begin
            o_quot = 32'(-quot_mag);
        end else if (quot_mag[31]) begin
            o_quot = 32'sh7FFFFFFF;
        end else begin
            o_quot = quot_mag[31:0];
        end
    end

    assign o_busy = r_busy;

endmodule

@@ hw/rtl/angle_gyro_bias_kalman_filter.sv @@
// An update word runs the prediction steps, then forms and tests the innovation variance, then
// performs two gain divisions, the correction steps and one output state. A non-positive variance
// skips straight to the output, and a load word goes straight to the output state. One word is in
// work at a time; the next is accepted in the cycle after the result leaves, and a stalled result
// holds the block.
// Synchronous active-low reset clears the estimates, covariance and control state and restores the noise defaults.
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman_filter
// Two-state angle and gyro bias filter for one tilt axis, sequenced over a
// shared multiplier and divider, with an APB register port for the noise.
// ----------------------------------------------------------------------------
module angle_gyro_bias_kalman_filter import agk_pkg::*; #(
    parameter int COV_FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic signed [24:0] i_measured_angle,
    input  logic signed [24:0] i_rate_in,
    input  logic [23:0]        i_time_step,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_angle_out,
    output logic signed [31:0] o_unbiased_rate,
    output logic signed [31:0] o_bias_out
);

    localparam logic [63:0] SCALE    = 64'd1 << COV_FRAC_BITS;
    localparam logic [30:0] QA_RESET = 31'((SCALE * 64'(NOISE_QA_MILLI) + 64'd500) / 64'd1000);
    localparam logic [30:0] QB_RESET = 31'((SCALE * 64'(NOISE_QB_MILLI) + 64'd500) / 64'd1000);
    localparam logic [30:0] R_RESET  = 31'((SCALE * 64'(NOISE_R_MILLI) + 64'd500) / 64'd1000);

    t_state r_state, n_state;
    t_mul_req mul_req;
    t_div_req div_req;
    logic signed [WIDE_W-1:0] rd;
    logic signed [31:0] div_quot;
    logic div_busy;
    logic in_fire, out_fire, cfg_wr;
    logic signed [WIDE_W-1:0] s_sum;

    logic [30:0] r_qa, r_qb, r_rn;
    logic signed [31:0] r_angle, r_bias, r_rate;
    logic signed [31:0] r_p00, r_p01, r_p10, r_p11;
    logic r_out_valid;

    logic signed [24:0] r_meas, r_rate_in;
    logic [23:0] r_dt;
    logic signed [WIDE_W-1:0] r_d;
    logic signed [31:0] r_inner, r_k0, r_k1, r_y;
    logic signed [33:0] r_s;

    logic signed [32:0] dt_op;

    agk_mul #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_req   (mul_req),
        .o_round (rd)
    );

    agk_div #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_fire  = i_in_valid && (r_state == ST_IDLE);
    assign out_fire = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign dt_op = {9'b0, r_dt};
    assign s_sum = wide32(r_p00) + {35'b0, r_rn};

    always_comb begin
        case (paddr[3:2])
            REG_ANGLE_NOISE: prdata = {1'b0, r_qa};
            REG_BIAS_NOISE:  prdata = {1'b0, r_qb};
            REG_MEAS_NOISE:  prdata = {1'b0, r_rn};
            default:         prdata = 32'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mul_req = '0;
        div_req = '0;
        div_req.den = r_s[32:0];
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_action ? ST_OUT : ST_RATE;
                end
            end
            ST_RATE:   n_state = ST_MUL_AR;
            ST_MUL_AR: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b0, a: dt_op, b: {r_rate[31], r_rate}};
                n_state = ST_UPD_AR;
            end
            ST_UPD_AR: n_state = ST_MUL_D;
            ST_MUL_D: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b0, a: dt_op, b: {r_p11[31], r_p11}};
                n_state = ST_UPD_D;
            end
            ST_UPD_D:  n_state = ST_MUL_P0;
            ST_MUL_P0: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b0, a: dt_op, b: {r_inner[31], r_inner}};
                n_state = ST_UPD_P0;
            end
            ST_UPD_P0: n_state = ST_MUL_P3;
            ST_MUL_P3: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b0, a: {2'b0, r_qb}, b: dt_op};
                n_state = ST_UPD_P3;
            end
            ST_UPD_P3: n_state = ST_SUM;
            ST_SUM:    n_state = ST_CHECK;
            ST_CHECK: begin
                if (!r_s[33] && (r_s != 34'sd0)) begin
                    n_state = ST_DIV0_GO;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV0_GO: begin
                div_req.start = 1'b1;
                div_req.num   = r_p00;
                n_state = ST_DIV0_WAIT;
            end
            ST_DIV0_WAIT: begin
                if (!div_busy) begin
                    n_state = ST_DIV1_GO;
                end
            end
            ST_DIV1_GO: begin
                div_req.start = 1'b1;
                div_req.num   = r_p10;
                n_state = ST_DIV1_WAIT;
            end
            ST_DIV1_WAIT: begin
                if (!div_busy) begin
                    n_state = ST_MUL_KA;
                end
            end
            ST_MUL_KA: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b1, a: {r_k0[31], r_k0}, b: {r_y[31], r_y}};
                n_state = ST_UPD_KA;
            end
            ST_UPD_KA: n_state = ST_MUL_KB;
            ST_MUL_KB: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b1, a: {r_k1[31], r_k1}, b: {r_y[31], r_y}};
                n_state = ST_UPD_KB;
            end
            ST_UPD_KB: n_state = ST_MUL_Q0;
            ST_MUL_Q0: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b1, a: {r_k0[31], r_k0}, b: {r_p00[31], r_p00}};
                n_state = ST_UPD_Q0;
            end
            ST_UPD_Q0: n_state = ST_MUL_Q1;
            ST_MUL_Q1: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b1, a: {r_k0[31], r_k0}, b: {r_p01[31], r_p01}};
                n_state = ST_UPD_Q1;
            end
            ST_UPD_Q1: n_state = ST_MUL_Q2;
            ST_MUL_Q2: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b1, a: {r_k1[31], r_k1}, b: {r_p00[31], r_p00}};
                n_state = ST_UPD_Q2;
            end
            ST_UPD_Q2: n_state = ST_MUL_Q3;
            ST_MUL_Q3: begin
                mul_req = '{en: 1'b1, cov_shift: 1'b1, a: {r_k1[31], r_k1}, b: {r_p01[31], r_p01}};
                n_state = ST_UPD_Q3;
            end
            ST_UPD_Q3: n_state = ST_OUT;
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa        <= QA_RESET;
            r_qb        <= QB_RESET;
            r_rn        <= R_RESET;
            r_angle     <= '0;
            r_bias      <= '0;
            r_rate      <= '0;
            r_p00       <= '0;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_ANGLE_NOISE: r_qa <= pwdata[30:0];
                    REG_BIAS_NOISE:  r_qb <= pwdata[30:0];
                    REG_MEAS_NOISE:  r_rn <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (out_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire && i_action) begin
                        r_angle <= {{7{i_measured_angle[24]}}, i_measured_angle};
                    end
                end
                ST_RATE: begin
                    r_rate <= sat32({{41{r_rate_in[24]}}, r_rate_in} - wide32(r_bias));
                end
                ST_UPD_AR: r_angle <= sat32(wide32(r_angle) + rd);
                ST_UPD_P0: begin
                    r_p00 <= sat32(wide32(r_p00) + rd);
                    r_p01 <= sat32(wide32(r_p01) - r_d);
                    r_p10 <= sat32(wide32(r_p10) - r_d);
                end
                ST_UPD_P3: r_p11 <= sat32(wide32(r_p11) + rd);
                ST_UPD_KA: r_angle <= sat32(wide32(r_angle) + rd);
                ST_UPD_KB: r_bias <= sat32(wide32(r_bias) + rd);
                ST_UPD_Q0: r_p00 <= sat32(wide32(r_p00) - rd);
                ST_UPD_Q1: r_p01 <= sat32(wide32(r_p01) - rd);
                ST_UPD_Q2: r_p10 <= sat32(wide32(r_p10) - rd);
                ST_UPD_Q3: r_p11 <= sat32(wide32(r_p11) - rd);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_meas    <= i_measured_angle;
            r_rate_in <= i_rate_in;
            r_dt      <= i_time_step;
        end
        case (r_state)
            ST_UPD_D: begin
                r_d     <= rd;
                r_inner <= sat32(rd - wide32(r_p01) - wide32(r_p10) + {35'b0, r_qa});
            end
            ST_SUM: r_s <= s_sum[33:0];
            ST_DIV0_WAIT: begin
                if (!div_busy) begin
                    r_k0 <= div_quot;
                end
            end
            ST_DIV1_WAIT: begin
                if (!div_busy) begin
                    r_k1 <= div_quot;
                    r_y  <= sat32({{41{r_meas[24]}}, r_meas} - wide32(r_angle));
                end
            end
            default: ;
        endcase
        if (out_fire) begin
            o_angle_out     <= r_angle;
            o_unbiased_rate <= r_rate;
            o_bias_out      <= r_bias;
        end
    end

endmodule
